// File: hdl/mbsp_pkg.sv
// shared types, status constants and helpers for the midi byte stream parser
package mbsp_pkg;

    // status byte values with a special role
    localparam logic [7:0] ST_SYSEX_START = 8'hF0;
    localparam logic [7:0] ST_TUNE_REQ    = 8'hF6;
    localparam logic [7:0] ST_SYSEX_END   = 8'hF7;
    localparam logic [7:0] ST_UNDEF_F4    = 8'hF4;
    localparam logic [7:0] ST_UNDEF_F5    = 8'hF5;
    localparam logic [7:0] ST_REALTIME_LO = 8'hF8;
    localparam logic [7:0] ST_NONE        = 8'h00;
    localparam logic [7:0] ST_MTC_QF      = 8'hF1;
    localparam logic [7:0] ST_SONG_POS    = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL    = 8'hF3;

    localparam logic [3:0] HI_PROG_CHANGE = 4'hC;
    localparam logic [3:0] HI_CHAN_PRESS  = 4'hD;
    localparam logic [3:0] HI_SYSTEM      = 4'hF;

    typedef enum logic
    {
        RC_ACCEPTED = 1'b0,
        RC_IGNORED  = 1'b1
    } mbsp_code_t;

    typedef struct packed
    {
        logic       message_valid;
        logic [7:0] status_out;
        logic [6:0] first_data;
        logic [6:0] second_data;
        mbsp_code_t result_code;
    } mbsp_result_t;

    // data bytes that follow a status byte
    function automatic logic [1:0] data_need(input logic [7:0] st);
        logic [1:0] need;
        need = 2'd0;
        if (st[7:4] == HI_PROG_CHANGE || st[7:4] == HI_CHAN_PRESS)
        begin
            need = 2'd1;
        end
        else if (st[7:4] != HI_SYSTEM)
        begin
            need = 2'd2;
        end
        else if (st == ST_MTC_QF || st == ST_SONG_SEL)
        begin
            need = 2'd1;
        end
        else if (st == ST_SONG_POS)
        begin
            need = 2'd2;
        end
        return need;
    endfunction

endpackage

// File: hdl/mbsp_byte_if.sv
// valid/ready channel carrying one received midi byte
interface mbsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

// File: hdl/mbsp_msg_if.sv
// valid/ready channel carrying one parse result
interface mbsp_msg_if;
    logic       valid;
    logic       ready;
    logic       message_valid;
    logic [7:0] status_out;
    logic [6:0] first_data;
    logic [6:0] second_data;
    logic       result_code;

    modport source (output valid, output message_valid, output status_out,
                    output first_data, output second_data, output result_code,
                    input ready);
    modport sink   (input valid, input message_valid, input status_out,
                    input first_data, input second_data, input result_code,
                    output ready);
endinterface

// File: hdl/mbsp_in_stage.sv
// input register holding one received byte until the parser takes it
module mbsp_in_stage
(
    input  logic        clk,
    input  logic        rst_n,
    mbsp_byte_if.sink   byte_in,
    input  logic        take,
    output logic        hold_valid,
    output logic [7:0]  hold_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;

    assign byte_in.ready = !valid_reg || take;
    assign valid_next    = byte_in.valid || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (byte_in.ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            byte_reg <= byte_in.stream_byte;
        end
    end

    assign hold_valid = valid_reg;
    assign hold_byte  = byte_reg;

`ifndef SYNTH
    // a held byte that is not taken blocks the next transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !take |-> !byte_in.ready)
        else $error("input stage accepts while full and stalled");
`endif

endmodule

// File: hdl/mbsp_decode.sv
// parse state and single pass decode of one byte
module mbsp_decode
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  fire,
    input  logic [7:0]            stream_byte,
    output mbsp_pkg::mbsp_result_t result
);

    logic [7:0] running_reg, running_next;
    logic [7:0] pending_reg, pending_next;
    logic [1:0] rcvd_reg, rcvd_next;
    logic [1:0] expect_reg, expect_next;
    logic       sysex_reg, sysex_next;
    logic [6:0] data0_reg, data0_next;
    logic [6:0] data1_reg, data1_next;

    always_comb
    begin
        logic [1:0] need;
        logic [7:0] b;
        b            = stream_byte;
        need         = mbsp_pkg::data_need(b);
        running_next = running_reg;
        pending_next = pending_reg;
        rcvd_next    = rcvd_reg;
        expect_next  = expect_reg;
        sysex_next   = sysex_reg;
        data0_next   = data0_reg;
        data1_next   = data1_reg;
        result               = '0;
        result.result_code   = mbsp_pkg::RC_ACCEPTED;

        if (b >= mbsp_pkg::ST_REALTIME_LO)
        begin
            // real time passes straight through
            result.message_valid = 1'b1;
            result.status_out    = b;
        end
        else if (b == mbsp_pkg::ST_SYSEX_START)
        begin
            sysex_next   = 1'b1;
            running_next = mbsp_pkg::ST_NONE;
            pending_next = mbsp_pkg::ST_NONE;
            rcvd_next    = 2'd0;
            expect_next  = 2'd0;
            result.result_code = mbsp_pkg::RC_IGNORED;
        end
        else if (b == mbsp_pkg::ST_SYSEX_END)
        begin
            if (sysex_reg)
            begin
                sysex_next           = 1'b0;
                result.message_valid = 1'b1;
                result.status_out    = mbsp_pkg::ST_SYSEX_START;
            end
            result.result_code = mbsp_pkg::RC_IGNORED;
        end
        else if (b == mbsp_pkg::ST_UNDEF_F4 || b == mbsp_pkg::ST_UNDEF_F5)
        begin
            result.result_code = mbsp_pkg::RC_IGNORED;
        end
        else if (b[7])
        begin
            sysex_next   = 1'b0;
            running_next = (b[7:4] != mbsp_pkg::HI_SYSTEM) ? b : mbsp_pkg::ST_NONE;
            pending_next = b;
            rcvd_next    = 2'd0;
            expect_next  = need;
            if (need == 2'd0)
            begin
                result.message_valid = 1'b1;
                result.status_out    = b;
            end
        end
        else if (sysex_reg)
        begin
            result.result_code = mbsp_pkg::RC_IGNORED;
        end
        else if (running_reg == mbsp_pkg::ST_NONE && expect_reg == 2'd0)
        begin
            // orphan data
            result.result_code = mbsp_pkg::RC_IGNORED;
        end
        else
        begin
            if (rcvd_reg < 2'd2)
            begin
                if (rcvd_reg[0])
                begin
                    data1_next = b[6:0];
                end
                else
                begin
                    data0_next = b[6:0];
                end
                rcvd_next = rcvd_reg + 2'd1;
            end
            if (rcvd_next >= expect_reg)
            begin
                result.message_valid = 1'b1;
                result.status_out    = pending_reg;
                result.first_data    = (expect_reg >= 2'd1) ? data0_next : 7'd0;
                result.second_data   = (expect_reg >= 2'd2) ? data1_next : 7'd0;
                rcvd_next            = 2'd0;
                if (pending_reg[7:4] == mbsp_pkg::HI_SYSTEM)
                begin
                    expect_next = 2'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= mbsp_pkg::ST_NONE;
            pending_reg <= mbsp_pkg::ST_NONE;
            rcvd_reg    <= 2'd0;
            expect_reg  <= 2'd0;
            sysex_reg   <= 1'b0;
            data0_reg   <= 7'd0;
            data1_reg   <= 7'd0;
        end
        else if (fire)
        begin
            running_reg <= running_next;
            pending_reg <= pending_next;
            rcvd_reg    <= rcvd_next;
            expect_reg  <= expect_next;
            sysex_reg   <= sysex_next;
            data0_reg   <= data0_next;
            data1_reg   <= data1_next;
        end
    end

`ifndef SYNTH
    // between bytes a message is never complete but unreported
    assert property (@(posedge clk) disable iff (!rst_n)
        (rcvd_reg < expect_reg) || (rcvd_reg == 2'd0))
        else $error("received count at or past expected count");

    // a sysex leaves no running status and no partial message
    assert property (@(posedge clk) disable iff (!rst_n)
        sysex_reg |-> (running_reg == mbsp_pkg::ST_NONE) && (expect_reg == 2'd0))
        else $error("parse state left over inside sysex");

    // running status only ever holds a channel status
    assert property (@(posedge clk) disable iff (!rst_n)
        (running_reg != mbsp_pkg::ST_NONE) |->
            running_reg[7] && (running_reg[7:4] != mbsp_pkg::HI_SYSTEM))
        else $error("running status holds a non channel byte");
`endif

endmodule

// File: hdl/mbsp_out_stage.sv
// result register feeding the output channel
module mbsp_out_stage
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load_valid,
    output logic                  load_ready,
    input  mbsp_pkg::mbsp_result_t result,
    mbsp_msg_if.source            msg_out
);

    logic                   valid_reg;
    mbsp_pkg::mbsp_result_t result_reg;

    assign load_ready = !valid_reg || msg_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load_ready)
        begin
            valid_reg <= load_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_valid && load_ready)
        begin
            result_reg <= result;
        end
    end

    assign msg_out.valid         = valid_reg;
    assign msg_out.message_valid = result_reg.message_valid;
    assign msg_out.status_out    = result_reg.status_out;
    assign msg_out.first_data    = result_reg.first_data;
    assign msg_out.second_data   = result_reg.second_data;
    assign msg_out.result_code   = logic'(result_reg.result_code);

`ifndef SYNTH
    // no completed message means all message fields read zero
    assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !result_reg.message_valid |->
            (result_reg.status_out == 8'd0) && (result_reg.first_data == 7'd0)
            && (result_reg.second_data == 7'd0))
        else $error("message fields nonzero without a message");
`endif

endmodule

// File: hdl/midi_byte_stream_parser.sv
// top level of the midi 1.0 byte stream parser
//
// Takes one MIDI 1.0 byte per transaction on byte_in and returns exactly one
// result transaction on msg_out for each byte, in order. A result carries a
// completion flag, the status of the completed message, up to two data bytes
// and an accepted/ignored code. Real-time bytes F8-FF complete at once and do
// not touch the parse state; channel messages keep running status; F1, F2, F3
// and F6 clear running status and report their own status; F4 and F5 are
// ignored; SysEx is only tracked and an F7 that ends it reports a bare F0
// message. Throughput is one byte per clock cycle, sustained, as long as
// msg_out is ready. A byte accepted on byte_in sits in the input register
// and is decoded into the result register, from which its result is offered
// on msg_out. The parse state is updated in the same cycle a byte leaves the
// input register. Back-pressure on msg_out stalls both registers; up to two
// bytes can be held inside while the output is stalled. No configuration and
// no clearing pass after reset.
module midi_byte_stream_parser
(
    input  logic        clk,
    input  logic        rst_n,
    mbsp_byte_if.sink   byte_in,
    mbsp_msg_if.source  msg_out
);

    // input register contents
    logic       hold_valid;
    logic [7:0] hold_byte;

    // result register can take a new result
    logic       load_ready;

    // byte moves from the input register into the result register
    logic       fire;

    mbsp_pkg::mbsp_result_t result;

    assign fire = hold_valid && load_ready;

    mbsp_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .take       (load_ready),
        .hold_valid (hold_valid),
        .hold_byte  (hold_byte)
    );

    // parse state lives here and advances on fire
    mbsp_decode u_decode
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .stream_byte (hold_byte),
        .result      (result)
    );

    mbsp_out_stage u_out_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (hold_valid),
        .load_ready (load_ready),
        .result     (result),
        .msg_out    (msg_out)
    );

`ifndef SYNTH
    // a result on the output always comes from a byte taken in the cycle before
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(msg_out.valid) |-> $past(fire))
        else $error("result appeared without a decoded byte");
`endif

endmodule
